@@ design/sbdft_pkg.sv @@
// shared types, constants and functions for the single-bin fourier coefficient block
// no dependencies
package sbdft_pkg;

    localparam int PHASE_BITS_DEF      = 24;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int MAX_SAMPLES_DEF     = 4194304;

    localparam int STEP_W     = 24;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int AMP_W      = 17;
    localparam int PHASE_W    = 15;
    localparam int CORDIC_N   = 16;
    localparam int IDX_W      = 4;
    localparam int Z_W        = 20;
    localparam int HALF_PI_Q  = 12868;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // commands from controller to datapath
    typedef struct packed {
        logic             take;
        logic             div_start;
        logic             div_step;
        logic             sat_load;
        logic             prep_load;
        logic             iter_step;
        logic [IDX_W-1:0] iter_idx;
        logic             out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic close_now;
        logic pipe_busy;
        logic out_busy;
    } t_stat;

    // cordic arctangent steps, q16 radians
    function automatic logic signed [Z_W-1:0] f_atan(input logic [IDX_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

    // first-quadrant sine in q1.14, taylor series in q30 (elaboration only)
    function automatic logic signed [15:0] f_qsine(input int unsigned j,
                                                   input int unsigned abits);
        logic [63:0] one;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] r;
        one = 64'd1 << 30;
        x   = (64'd2 * PI_Q30 * 64'(j)) >> abits;
        x2  = (x * x) >> 30;
        t   = one - x2 / 64'd110;
        t   = one - ((x2 * t) >> 30) / 64'd72;
        t   = one - ((x2 * t) >> 30) / 64'd42;
        t   = one - ((x2 * t) >> 30) / 64'd20;
        t   = one - ((x2 * t) >> 30) / 64'd6;
        r   = (x * t) >> 30;
        r   = (r + (64'd1 << 15)) >> 16;
        if (r > 64'd16384) r = 64'd16384;
        return 16'(r);
    endfunction

endpackage

@@ design/single_bin_fourier_coefficient.sv @@
// top level of the single-bin fourier coefficient block
// depends on sbdft_pkg, sbdft_ctrl and sbdft_dp
//
// usage:
// samples enter on a valid/ready channel (i_sample, i_last_sample). while a
// window is open one sample is taken every cycle. the sample with
// i_last_sample set, or the one that fills the window to MAX_SAMPLES, closes
// it; o_ready then drops while the mac pipeline drains, the quotient
// divider runs (one bit per cycle), the coefficients saturate, the
// squares form, the shared 16-step root and cordic unit runs, and the
// result is then loaded into the output register.
// the result waits in its register until o_valid and i_ready meet; a new
// window may be accumulated meanwhile, and its close holds in the load step
// until the earlier transaction has gone. i_cfg_we writes phase_step at any
// clock edge; write it only while idle. synchronous reset clears the phase,
// the sums, the count, phase_step and all handshake state.
module single_bin_fourier_coefficient #(
    parameter int PHASE_BITS      = sbdft_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = sbdft_pkg::TABLE_ADDR_BITS_DEF,
    parameter int MAX_SAMPLES     = sbdft_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sbdft_pkg::STEP_W-1:0]          i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [sbdft_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                  i_last_sample,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [sbdft_pkg::COEF_W-1:0]   o_cos_coefficient,
    output logic signed [sbdft_pkg::COEF_W-1:0]   o_sin_coefficient,
    output logic [sbdft_pkg::AMP_W-1:0]           o_amplitude,
    output logic signed [sbdft_pkg::PHASE_W-1:0]  o_phase_angle
);

    localparam int DIV_STEPS = 31 + $clog2(MAX_SAMPLES + 1);

    sbdft_pkg::t_cmd  cmd;
    sbdft_pkg::t_stat stat;

    // controller
    sbdft_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath
    sbdft_dp #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .MAX_SAMPLES     (MAX_SAMPLES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_sample          (i_sample),
        .i_last_sample     (i_last_sample),
        .i_out_ready       (i_ready),
        .o_valid           (o_valid),
        .o_cos_coefficient (o_cos_coefficient),
        .o_sin_coefficient (o_sin_coefficient),
        .o_amplitude       (o_amplitude),
        .o_phase_angle     (o_phase_angle)
    );

endmodule

@@ design/sbdft_ctrl.sv @@
// controller state machine for the single-bin fourier coefficient block
// depends on sbdft_pkg
module sbdft_ctrl #(
    parameter int DIV_STEPS = 54
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sbdft_pkg::t_stat i_stat,
    output sbdft_pkg::t_cmd  o_cmd
);

    localparam int CTR_W = $clog2(DIV_STEPS);

    localparam logic [2:0] S_ACC   = 3'd0;
    localparam logic [2:0] S_DRAIN = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SAT   = 3'd3;
    localparam logic [2:0] S_PREP  = 3'd4;
    localparam logic [2:0] S_ITER  = 3'd5;
    localparam logic [2:0] S_LOAD  = 3'd6;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CTR_W-1:0] r_ctr;
    logic [CTR_W-1:0] n_ctr;

    assign o_ready = (r_state == S_ACC);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_ctr   = r_ctr;
        o_cmd   = '0;
        o_cmd.iter_idx = r_ctr[sbdft_pkg::IDX_W-1:0];
        case (r_state)
            S_ACC: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.close_now) n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_ctr   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_ctr = r_ctr + 1'b1;
                if (r_ctr == CTR_W'(DIV_STEPS - 1)) n_state = S_SAT;
            end
            S_SAT: begin
                o_cmd.sat_load = 1'b1;
                n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep_load = 1'b1;
                n_ctr   = '0;
                n_state = S_ITER;
            end
            S_ITER: begin
                o_cmd.iter_step = 1'b1;
                n_ctr = r_ctr + 1'b1;
                if (r_ctr == CTR_W'(sbdft_pkg::CORDIC_N - 1)) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_ctr   <= '0;
        end else begin
            r_state <= n_state;
            r_ctr   <= n_ctr;
        end
    end

endmodule

@@ design/sbdft_dp.sv @@
// datapath: phase accumulator, sine table, mac, divider, root and cordic units
// depends on sbdft_pkg
module sbdft_dp #(
    parameter int PHASE_BITS      = sbdft_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = sbdft_pkg::TABLE_ADDR_BITS_DEF,
    parameter int MAX_SAMPLES     = sbdft_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sbdft_pkg::t_cmd               i_cmd,
    output sbdft_pkg::t_stat              o_stat,
    input  logic                          i_cfg_we,
    input  logic [sbdft_pkg::STEP_W-1:0]  i_cfg_data,
    input  logic signed [sbdft_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_last_sample,
    input  logic                          i_out_ready,
    output logic                          o_valid,
    output logic signed [sbdft_pkg::COEF_W-1:0]  o_cos_coefficient,
    output logic signed [sbdft_pkg::COEF_W-1:0]  o_sin_coefficient,
    output logic [sbdft_pkg::AMP_W-1:0]          o_amplitude,
    output logic signed [sbdft_pkg::PHASE_W-1:0] o_phase_angle
);

    localparam int P       = PHASE_BITS;
    localparam int A       = TABLE_ADDR_BITS;
    localparam int TAB     = 1 << A;
    localparam int QUARTER = TAB / 4;
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = 31 + CNT_W;
    localparam int MW      = (P > sbdft_pkg::STEP_W) ? P + 1 : sbdft_pkg::STEP_W + 1;
    localparam int SHR     = (P >= A) ? P - A : 0;
    localparam int SHL     = (A > P) ? A - P : 0;
    localparam int XW      = 34;
    localparam int ZW      = sbdft_pkg::Z_W;

    typedef logic signed [15:0] t_tab [TAB];

    // full-turn sine table built from the first quadrant
    function automatic t_tab f_build();
        t_tab tb;
        int unsigned q;
        int unsigned m;
        for (int k = 0; k < TAB; k++) begin
            q = k / QUARTER;
            m = k % QUARTER;
            if (q == 0)      tb[k] = sbdft_pkg::f_qsine(m, A);
            else if (q == 1) tb[k] = sbdft_pkg::f_qsine(QUARTER - m, A);
            else if (q == 2) tb[k] = -sbdft_pkg::f_qsine(m, A);
            else             tb[k] = -sbdft_pkg::f_qsine(QUARTER - m, A);
        end
        return tb;
    endfunction

    localparam t_tab SINE_TAB = f_build();

    // truncated quotient magnitude to saturated signed coefficient
    function automatic logic signed [15:0] f_sat(input logic [SUM_W-1:0] q,
                                                 input logic neg);
        logic [SUM_W-15:0] m;
        m = q[SUM_W-1:14];
        if (!neg) return (m > (SUM_W-14)'(32767)) ? 16'sd32767 : 16'(m[15:0]);
        return (m > (SUM_W-14)'(32768)) ? -16'sd32768 : 16'(~m[15:0] + 16'd1);
    endfunction

    // window state
    logic [sbdft_pkg::STEP_W-1:0] r_step;
    logic [P-1:0]                 r_acc;
    logic [CNT_W-1:0]             r_cnt;
    logic signed [SUM_W-1:0]      r_csum;
    logic signed [SUM_W-1:0]      r_ssum;

    // mac pipeline
    logic                         r_s1_v, r_s2_v, r_s3_v;
    logic [A-1:0]                 r_addr;
    logic signed [15:0]           r_s1_x, r_s2_x;
    logic signed [15:0]           r_cv, r_sv;
    logic signed [31:0]           r_cp, r_sp;

    // divider lanes
    logic [SUM_W-1:0]             r_dc, r_ds;
    logic [CNT_W-1:0]             r_rc, r_rs, r_div;
    logic                         r_negc, r_negs;

    // result units
    logic signed [15:0]           r_a, r_b;
    logic [31:0]                  r_v;
    logic [31:0]                  r_bit;
    logic [31:0]                  r_res;
    logic signed [XW-1:0]         r_x, r_y;
    logic signed [ZW-1:0]         r_z;

    logic                         r_out_v;

    logic [MW-1:0]                acc_sum;
    logic [P+A-1:0]               addr_w;
    logic [A-1:0]                 addr_s;
    logic [CNT_W:0]               cnt_inc;
    logic [CNT_W:0]               tc, ts;
    logic                         gc, gs;
    logic signed [16:0]           ea, eb;
    logic signed [XW-1:0]         xs, ys;
    logic [32:0]                  rb;
    logic signed [ZW-1:0]         zr;
    logic signed [sbdft_pkg::PHASE_W-1:0] ph;

    // phase step and table address
    assign acc_sum = MW'(r_acc) + MW'(r_step);
    assign addr_w  = ((P+A)'(r_acc) >> SHR) << SHL;
    assign addr_s  = addr_w[A-1:0];
    assign cnt_inc = (CNT_W+1)'(r_cnt) + 1'b1;

    assign o_stat.close_now = i_last_sample || (cnt_inc == (CNT_W+1)'(MAX_SAMPLES));
    assign o_stat.pipe_busy = r_s1_v || r_s2_v || r_s3_v;
    assign o_stat.out_busy  = r_out_v;
    assign o_valid          = r_out_v;

    // divider step, one quotient bit per lane
    assign tc = {r_rc, r_dc[SUM_W-1]};
    assign ts = {r_rs, r_ds[SUM_W-1]};
    assign gc = tc >= {1'b0, r_div};
    assign gs = ts >= {1'b0, r_div};

    // cordic and root step terms
    assign ea = r_b[15] ? -17'(r_b) : 17'(r_b);
    assign eb = r_b[15] ? -17'(r_a) : 17'(r_a);
    assign xs = r_x >>> i_cmd.iter_idx;
    assign ys = r_y >>> i_cmd.iter_idx;
    assign rb = 33'(r_res) + 33'(r_bit);

    // final angle rounding and special cases
    always_comb begin
        zr = (r_z + ZW'(4)) >>> 3;
        if (r_b == 16'sd0) begin
            if (r_a > 16'sd0)      ph = 15'(sbdft_pkg::HALF_PI_Q);
            else if (r_a < 16'sd0) ph = -15'(sbdft_pkg::HALF_PI_Q);
            else                   ph = '0;
        end else if (r_a == 16'sd0) begin
            ph = '0;
        end else if (zr > ZW'(sbdft_pkg::HALF_PI_Q)) begin
            ph = 15'(sbdft_pkg::HALF_PI_Q);
        end else if (zr < -ZW'(sbdft_pkg::HALF_PI_Q)) begin
            ph = -15'(sbdft_pkg::HALF_PI_Q);
        end else begin
            ph = zr[sbdft_pkg::PHASE_W-1:0];
        end
    end

    // control state and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_csum  <= '0;
            r_ssum  <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) r_step <= i_cfg_data;
            r_s1_v <= i_cmd.take;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            if (i_cmd.take) begin
                r_acc <= acc_sum[P-1:0];
                r_cnt <= cnt_inc[CNT_W-1:0];
            end
            if (r_s3_v) begin
                r_csum <= r_csum + SUM_W'(r_cp);
                r_ssum <= r_ssum + SUM_W'(r_sp);
            end
            if (i_cmd.div_start) begin
                r_acc  <= '0;
                r_cnt  <= '0;
                r_csum <= '0;
                r_ssum <= '0;
            end
            if (i_cmd.out_load)              r_out_v <= 1'b1;
            else if (r_out_v && i_out_ready) r_out_v <= 1'b0;
        end
    end

    // payload: mac pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_addr <= addr_s;
            r_s1_x <= i_sample;
        end
        r_s2_x <= r_s1_x;
        r_sv   <= SINE_TAB[r_addr];
        r_cv   <= SINE_TAB[r_addr + A'(QUARTER)];
        r_cp   <= r_s2_x * r_cv;
        r_sp   <= r_s2_x * r_sv;
    end

    // payload: divider, saturation, root and cordic
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dc   <= r_csum[SUM_W-1] ? SUM_W'(-r_csum) : SUM_W'(r_csum);
            r_ds   <= r_ssum[SUM_W-1] ? SUM_W'(-r_ssum) : SUM_W'(r_ssum);
            r_negc <= r_csum[SUM_W-1];
            r_negs <= r_ssum[SUM_W-1];
            r_rc   <= '0;
            r_rs   <= '0;
            r_div  <= r_cnt;
        end
        if (i_cmd.div_step) begin
            r_rc <= gc ? CNT_W'(tc - {1'b0, r_div}) : tc[CNT_W-1:0];
            r_rs <= gs ? CNT_W'(ts - {1'b0, r_div}) : ts[CNT_W-1:0];
            r_dc <= {r_dc[SUM_W-2:0], gc};
            r_ds <= {r_ds[SUM_W-2:0], gs};
        end
        if (i_cmd.sat_load) begin
            r_a <= f_sat(r_dc, r_negc);
            r_b <= f_sat(r_ds, r_negs);
        end
        if (i_cmd.prep_load) begin
            r_v   <= 32'(r_a * r_a) + 32'(r_b * r_b);
            r_bit <= 32'd1 << 30;
            r_res <= '0;
            r_x   <= XW'(ea) <<< 14;
            r_y   <= XW'(eb) <<< 14;
            r_z   <= '0;
        end
        if (i_cmd.iter_step) begin
            if (33'(r_v) >= rb) begin
                r_v   <= 32'(33'(r_v) - rb);
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + sbdft_pkg::f_atan(i_cmd.iter_idx);
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - sbdft_pkg::f_atan(i_cmd.iter_idx);
            end
        end
        if (i_cmd.out_load) begin
            o_cos_coefficient <= r_a;
            o_sin_coefficient <= r_b;
            o_amplitude       <= sbdft_pkg::AMP_W'(r_res);
            o_phase_angle     <= ph;
        end
    end

endmodule

@@ verif/single_bin_fourier_coefficient_tb.sv @@
// testbench for the single-bin fourier coefficient block
// depends on sbdft_pkg and single_bin_fourier_coefficient; predicts each window result itself
module single_bin_fourier_coefficient_tb;

    localparam int TAB_N     = 1 << sbdft_pkg::TABLE_ADDR_BITS_DEF;
    localparam int TAB_SHIFT = sbdft_pkg::PHASE_BITS_DEF - sbdft_pkg::TABLE_ADDR_BITS_DEF;
    localparam int CYCLE_CAP = 600000;
    localparam int SETTLE    = 120;
    localparam int EXP_DEPTH = 64;
    localparam logic [63:0] PI_TURN_Q30 = 64'd3373259426;
    localparam int ATAN_Q16 [sbdft_pkg::CORDIC_N] = '{51472, 30386, 16055, 8150, 4091, 2047,
                                                     1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

    typedef struct {
        logic signed [sbdft_pkg::COEF_W-1:0]  cos_c;
        logic signed [sbdft_pkg::COEF_W-1:0]  sin_c;
        logic [sbdft_pkg::AMP_W-1:0]          amp;
        logic signed [sbdft_pkg::PHASE_W-1:0] ang;
    } t_coef;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_cfg_we;
    logic [sbdft_pkg::STEP_W-1:0]          i_cfg_data;
    logic                                  i_valid;
    logic                                  o_ready;
    logic signed [sbdft_pkg::SAMPLE_W-1:0] i_sample;
    logic                                  i_last_sample;
    logic                                  o_valid;
    logic                                  i_ready;
    logic signed [sbdft_pkg::COEF_W-1:0]   o_cos_coefficient;
    logic signed [sbdft_pkg::COEF_W-1:0]   o_sin_coefficient;
    logic [sbdft_pkg::AMP_W-1:0]           o_amplitude;
    logic signed [sbdft_pkg::PHASE_W-1:0]  o_phase_angle;

    // predictor state
    logic signed [15:0]           sine_rom [TAB_N];
    logic [sbdft_pkg::STEP_W-1:0] step_reg;
    logic [sbdft_pkg::STEP_W-1:0] phase_acc;
    longint                       cos_acc;
    longint                       sin_acc;
    longint                       win_count;
    t_coef                        exp_ring [EXP_DEPTH];
    int                           exp_wr;
    int                           exp_rd;
    int                           mismatches;
    int                           cycles;

    single_bin_fourier_coefficient DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .i_last_sample     (i_last_sample),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_cos_coefficient (o_cos_coefficient),
        .o_sin_coefficient (o_sin_coefficient),
        .o_amplitude       (o_amplitude),
        .o_phase_angle     (o_phase_angle)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // quarter-wave sine by taylor series in q30, rounded to q1.14
    function automatic logic signed [15:0] quarter_sine(input int unsigned j);
        longint unsigned unit, x, x2, t, r;
        unit = 64'd1 << 30;
        x    = (64'd2 * PI_TURN_Q30 * j) >> sbdft_pkg::TABLE_ADDR_BITS_DEF;
        x2   = (x * x) >> 30;
        t    = unit - x2 / 110;
        t    = unit - ((x2 * t) >> 30) / 72;
        t    = unit - ((x2 * t) >> 30) / 42;
        t    = unit - ((x2 * t) >> 30) / 20;
        t    = unit - ((x2 * t) >> 30) / 6;
        r    = (((x * t) >> 30) + (64'd1 << 15)) >> 16;
        if (r > 16384) r = 16384;
        return 16'(r);
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint root_floor(input longint v);
        longint r, c;
        r = 0;
        for (int k = 16; k >= 0; k--) begin
            c = r | (longint'(1) << k);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    // cordic vectoring angle of (b, a), q16 rounded to q2.13
    function automatic longint angle_of(input longint a, input longint b);
        longint x, y, z, xs, ys;
        if (b == 0) begin
            return (a > 0) ? sbdft_pkg::HALF_PI_Q : (a < 0) ? -sbdft_pkg::HALF_PI_Q : 0;
        end
        if (a == 0) return 0;
        if (b < 0) begin
            a = -a;
            b = -b;
        end
        x = b * 16384;
        y = a * 16384;
        z = 0;
        for (int i = 0; i < sbdft_pkg::CORDIC_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += ATAN_Q16[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_Q16[i];
            end
        end
        z = (z + 4) >>> 3;
        if (z > sbdft_pkg::HALF_PI_Q) z = sbdft_pkg::HALF_PI_Q;
        if (z < -sbdft_pkg::HALF_PI_Q) z = -sbdft_pkg::HALF_PI_Q;
        return z;
    endfunction

    // fold one accepted sample into the window, store a result on close
    function automatic void fold_sample(input logic signed [15:0] s, input logic last);
        int    addr;
        longint a, b;
        t_coef r;
        addr = int'(phase_acc >> TAB_SHIFT);
        cos_acc += longint'(s) * sine_rom[(addr + TAB_N / 4) % TAB_N];
        sin_acc += longint'(s) * sine_rom[addr];
        win_count++;
        phase_acc = phase_acc + step_reg;
        if (!last && win_count < sbdft_pkg::MAX_SAMPLES_DEF) return;
        a = clamp16((cos_acc / win_count) / 16384);
        b = clamp16((sin_acc / win_count) / 16384);
        r.cos_c = sbdft_pkg::COEF_W'(a);
        r.sin_c = sbdft_pkg::COEF_W'(b);
        r.amp   = sbdft_pkg::AMP_W'(root_floor(a * a + b * b));
        r.ang   = sbdft_pkg::PHASE_W'(angle_of(a, b));
        exp_ring[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
        phase_acc = '0;
        cos_acc   = 0;
        sin_acc   = 0;
        win_count = 0;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result check on every output transaction
    always @(posedge i_clk) begin
        t_coef e;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_wr == exp_rd) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result cos=%0d sin=%0d amp=%0d ang=%0d",
                             o_cos_coefficient, o_sin_coefficient, o_amplitude,
                             o_phase_angle);
            end else begin
                e = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_cos_coefficient !== e.cos_c || o_sin_coefficient !== e.sin_c ||
                    o_amplitude !== e.amp || o_phase_angle !== e.ang) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 e.cos_c, e.sin_c, e.amp, e.ang, o_cos_coefficient,
                                 o_sin_coefficient, o_amplitude, o_phase_angle);
                end
            end
        end
    end

    // receiver stalls: mostly ready, sometimes long holds
    initial begin
        int n;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("single_bin_fourier_coefficient_tb: errors");
            $finish;
        end
    end

    // one sample transaction
    task automatic send_sample(input logic signed [15:0] s, input logic last,
                               input bit gaps = 1'b1);
        int n;
        n = gaps ? pick_gap() : 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample      <= s;
        i_last_sample <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        fold_sample(s, last);
    endtask

    task automatic drain();
        while (exp_wr != exp_rd) @(posedge i_clk);
    endtask

    // idle the block, then write the phase step
    task automatic set_step(input logic [sbdft_pkg::STEP_W-1:0] v);
        i_valid <= 1'b0;
        drain();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        step_reg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_sample();
        int p;
        p = $urandom_range(9);
        if (p == 0) return 16'sh7fff;
        if (p == 1) return 16'sh8000;
        return 16'($urandom);
    endfunction

    // zero step: pure dc windows, b always zero
    task automatic test_dc_windows();
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh0000, 1'b1);
        send_sample(16'sh1234, 1'b0);
        send_sample(16'shedcb, 1'b1);
    endtask

    // quarter, half and near-full turn steps: a zero, negative b, diagonal angles
    task automatic test_special_angles();
        set_step(24'h400000);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh4000, 1'b1);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sh4000, 1'b1);
        send_sample(16'sh4000, 1'b0);
        send_sample(16'sh4000, 1'b1);
        send_sample(-16'sh4000, 1'b0);
        send_sample(-16'sh4000, 1'b1);
        set_step(24'h800000);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b1);
        set_step(24'hffffff);
        for (int i = 0; i < 6; i++) send_sample(16'sh8000, i == 5);
    endtask

    // random windows, mostly short, the odd long one
    task automatic test_random_windows(input int items);
        int len;
        int sent;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
            sent += len;
        end
    endtask

    // sender holds off until every result has come
    task automatic test_hold_off();
        for (int w = 0; w < 4; w++) begin
            for (int i = 0; i < 5; i++) send_sample(rand_sample(), i == 4, 1'b0);
            i_valid <= 1'b0;
            drain();
        end
    endtask

    initial begin
        mismatches = 0;
        cycles     = 0;
        exp_wr     = 0;
        exp_rd     = 0;
        step_reg   = '0;
        phase_acc  = '0;
        cos_acc    = 0;
        sin_acc    = 0;
        win_count  = 0;
        for (int k = 0; k < TAB_N; k++) begin
            case (k / (TAB_N / 4))
                0:       sine_rom[k] = quarter_sine(k % (TAB_N / 4));
                1:       sine_rom[k] = quarter_sine(TAB_N / 4 - k % (TAB_N / 4));
                2:       sine_rom[k] = -quarter_sine(k % (TAB_N / 4));
                default: sine_rom[k] = -quarter_sine(TAB_N / 4 - k % (TAB_N / 4));
            endcase
        end
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_sample      = '0;
        i_last_sample = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_dc_windows();
        test_special_angles();
        set_step(24'h000000);
        test_random_windows(100);
        set_step(24'hffffff);
        test_random_windows(100);
        test_hold_off();
        for (int p = 0; p < 5; p++) begin
            set_step(24'($urandom));
            test_random_windows(110);
        end
        set_step(24'h000001);
        test_random_windows(80);

        i_valid <= 1'b0;
        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("single_bin_fourier_coefficient_tb: clean");
        end else begin
            $display("single_bin_fourier_coefficient_tb: errors");
        end
        $finish;
    end

endmodule
